FILE: design/amsp_pkg.sv
`default_nettype none
package amsp_pkg;

  localparam int NODE_W  = 7;
  localparam int IN_W    = 32;
  localparam int ENTRY_W = 48;

  typedef enum logic {
    CMD_STAMP = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_ZERO  = 2'd2,
    ST_SAT   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_SQR,
    B_SQX,
    B_DIV,
    B_RD,
    B_RDW,
    B_DONE
  } bstate_e;

  // classified request as it travels from front to back
  typedef struct packed {
    cmd_e              cmd;
    logic [NODE_W-1:0] fn;
    logic [NODE_W-1:0] tn;
    logic [IN_W-1:0]   r;
    logic [IN_W-1:0]   x;
    logic [IN_W-1:0]   b;
    status_e           cls;
  } item_t;

endpackage
`default_nettype wire

FILE: design/amsp_front.sv
`default_nettype none
module amsp_front #(
  parameter int MAX_NODES = 64
) (
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      command_i,
  input  wire logic [6:0]                from_node_i,
  input  wire logic [6:0]                to_node_i,
  input  wire logic [31:0]               resistance_i,
  input  wire logic [31:0]               reactance_i,
  input  wire logic [31:0]               charging_i,
  input  wire logic                      q_full_i,
  input  wire logic                      clearing_i,
  output logic                           push_o,
  output amsp_pkg::item_t                item_o
);
  import amsp_pkg::*;

  logic nodes_ok;

  assign nodes_ok = (from_node_i != '0) && (32'(from_node_i) <= MAX_NODES) &&
                    (to_node_i != '0) && (32'(to_node_i) <= MAX_NODES);

  always_comb begin
    item_o.cmd = cmd_e'(command_i);
    item_o.fn  = from_node_i;
    item_o.tn  = to_node_i;
    item_o.r   = resistance_i;
    item_o.x   = reactance_i;
    item_o.b   = charging_i;
    priority if (!nodes_ok) begin
      item_o.cls = ST_RANGE;
    end else if (command_i == CMD_STAMP && resistance_i == '0 && reactance_i == '0) begin
      item_o.cls = ST_ZERO;
    end else begin
      item_o.cls = ST_OK;
    end
  end

  assign in_stall_o = q_full_i | clearing_i;
  assign push_o     = in_valid_i & ~in_stall_o;

endmodule
`default_nettype wire

FILE: design/amsp_fifo.sv
`default_nettype none
module amsp_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire amsp_pkg::item_t item_i,
  input  wire logic            pop_i,
  output amsp_pkg::item_t      item_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import amsp_pkg::*;

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

FILE: design/amsp_div.sv
`default_nettype none
// two restoring dividers in lockstep: floor(mag * 2^(2F) / den), one bit per cycle
module amsp_div #(
  parameter int FRAC_BITS = 24
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [31:0]              mag_a_i,
  input  wire logic [31:0]              mag_b_i,
  input  wire logic [63:0]              den_i,
  output logic                          done_o,
  output logic [2*FRAC_BITS:0]          quo_a_o,
  output logic [2*FRAC_BITS:0]          quo_b_o
);
  localparam int SH    = 2 * FRAC_BITS;
  localparam int DW    = 32 + SH;
  localparam int QW    = SH + 1;
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    dvd_a_q, dvd_b_q;
  logic [63:0]      rem_a_q, rem_b_q, den_q;
  logic [QW-1:0]    q_a_q, q_b_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic [63:0]      t_a, t_b;
  logic             ge_a, ge_b;

  assign t_a  = {rem_a_q[62:0], dvd_a_q[DW-1]};
  assign t_b  = {rem_b_q[62:0], dvd_b_q[DW-1]};
  assign ge_a = t_a >= den_q;
  assign ge_b = t_b >= den_q;

  assign done_o  = busy_q && (cnt_q == CNT_W'(DW));
  assign quo_a_o = q_a_q;
  assign quo_b_o = q_b_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_a_q <= {mag_a_i, SH'(0)};
      dvd_b_q <= {mag_b_i, SH'(0)};
      rem_a_q <= '0;
      rem_b_q <= '0;
      q_a_q   <= '0;
      q_b_q   <= '0;
      den_q   <= den_i;
    end else if (busy_q && !done_o) begin
      dvd_a_q <= {dvd_a_q[DW-2:0], 1'b0};
      dvd_b_q <= {dvd_b_q[DW-2:0], 1'b0};
      rem_a_q <= ge_a ? t_a - den_q : t_a;
      rem_b_q <= ge_b ? t_b - den_q : t_b;
      q_a_q   <= {q_a_q[QW-2:0], ge_a};
      q_b_q   <= {q_b_q[QW-2:0], ge_b};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: design/amsp_back.sv
`default_nettype none
module amsp_back #(
  parameter int MAX_NODES = 64,
  parameter int FRAC_BITS = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire amsp_pkg::item_t    item_i,
  input  wire logic               empty_i,
  output logic                    pop_o,
  output logic                    clearing_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [47:0]             entry_real_o,
  output logic [47:0]             entry_imag_o,
  output logic [6:0]              highest_node_seen_o,
  output logic [1:0]              status_o
);
  import amsp_pkg::*;

  localparam int DEPTH  = MAX_NODES * MAX_NODES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int QW     = 2 * FRAC_BITS + 1;
  localparam int VW     = ((2 * FRAC_BITS + 2) > 32 ? 2 * FRAC_BITS + 2 : 32) + 1;
  localparam int SW     = (VW > ENTRY_W ? VW : ENTRY_W) + 1;

  bstate_e state_q, state_d;

  // matrix store: real in the upper half, imaginary in the lower half
  logic [2*ENTRY_W-1:0] mem [DEPTH];
  logic [2*ENTRY_W-1:0] rdata_q, wdata;
  logic [ADDR_W-1:0]    raddr, waddr, clr_q;
  logic                 we;

  item_t                it_q;
  logic [63:0]          rsq_q;
  logic [31:0]          rm, xm;
  logic                 div_start, div_done;
  logic [QW-1:0]        gq, sq;
  logic signed [VW-1:0] g_q, s_q, hb, dre, dim;
  logic [1:0]           upd_q;
  logic [NODE_W-1:0]    row, col, hn_q, hmax;
  logic signed [SW-1:0] sum_re, sum_im;
  logic [ENTRY_W-1:0]   new_re, new_im;
  logic                 sat_re, sat_im;
  logic [ENTRY_W-1:0]   res_re_q, res_im_q;
  status_e              res_st_q;
  logic                 out_free;

  function automatic logic [ADDR_W-1:0] slot(input logic [NODE_W-1:0] r,
                                             input logic [NODE_W-1:0] c);
    slot = ADDR_W'((32'(r) - 32'd1) * MAX_NODES + (32'(c) - 32'd1));
  endfunction

  assign rm = it_q.r[31] ? 32'(-it_q.r) : it_q.r;
  assign xm = it_q.x[31] ? 32'(-it_q.x) : it_q.x;

  amsp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_a_i (rm),
    .mag_b_i (xm),
    .den_i   (rsq_q + 64'(xm) * 64'(xm)),
    .done_o  (div_done),
    .quo_a_o (gq),
    .quo_b_o (sq)
  );

  // entry order of a stamp: (f,t), (t,f), (f,f), (t,t)
  always_comb begin
    unique case (upd_q)
      2'd0:    begin row = it_q.fn; col = it_q.tn; end
      2'd1:    begin row = it_q.tn; col = it_q.fn; end
      2'd2:    begin row = it_q.fn; col = it_q.fn; end
      default: begin row = it_q.tn; col = it_q.tn; end
    endcase
  end

  assign hb  = VW'($signed(it_q.b)) >>> 1;
  assign dre = upd_q[1] ? g_q : -g_q;
  assign dim = upd_q[1] ? s_q + hb : -s_q;

  assign sum_re = SW'($signed(rdata_q[2*ENTRY_W-1:ENTRY_W])) + SW'(dre);
  assign sum_im = SW'($signed(rdata_q[ENTRY_W-1:0])) + SW'(dim);
  assign sat_re = (sum_re[SW-1:ENTRY_W-1] != '0) && (sum_re[SW-1:ENTRY_W-1] != '1);
  assign sat_im = (sum_im[SW-1:ENTRY_W-1] != '0) && (sum_im[SW-1:ENTRY_W-1] != '1);
  assign new_re = !sat_re ? sum_re[ENTRY_W-1:0] :
                  sum_re[SW-1] ? {1'b1, {(ENTRY_W-1){1'b0}}} : {1'b0, {(ENTRY_W-1){1'b1}}};
  assign new_im = !sat_im ? sum_im[ENTRY_W-1:0] :
                  sum_im[SW-1] ? {1'b1, {(ENTRY_W-1){1'b0}}} : {1'b0, {(ENTRY_W-1){1'b1}}};

  assign hmax     = (it_q.fn > it_q.tn) ? it_q.fn : it_q.tn;
  assign out_free = !out_valid_o || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_CLEAR: if (32'(clr_q) == DEPTH - 1) state_d = B_IDLE;
      B_IDLE: begin
        if (!empty_i) begin
          priority if (item_i.cls != ST_OK) state_d = B_DONE;
          else if (item_i.cmd == CMD_READ) state_d = B_RD;
          else state_d = B_SQR;
        end
      end
      B_SQR:  state_d = B_SQX;
      B_SQX:  state_d = B_DIV;
      B_DIV:  if (div_done) state_d = B_RD;
      B_RD:   state_d = B_RDW;
      B_RDW:  state_d = (it_q.cmd == CMD_READ || upd_q == 2'd3) ? B_DONE : B_RD;
      B_DONE: if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop_o      = 1'b0;
    div_start  = 1'b0;
    we         = 1'b0;
    waddr      = slot(row, col);
    wdata      = {new_re, new_im};
    raddr      = slot(row, col);
    clearing_o = 1'b0;
    unique case (state_q)
      B_CLEAR: begin
        clearing_o = 1'b1;
        we         = 1'b1;
        waddr      = clr_q;
        wdata      = '0;
      end
      B_IDLE:  pop_o = !empty_i;
      B_SQX:   div_start = 1'b1;
      B_RDW:   we = (it_q.cmd == CMD_STAMP);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) it_q <= item_i;
    if (state_q == B_SQR) rsq_q <= 64'(rm) * 64'(rm);
    if (state_q == B_DIV && div_done) begin
      g_q <= it_q.r[31] ? -VW'(gq) : VW'(gq);
      s_q <= ($signed(it_q.x) > 0) ? -VW'(sq) : VW'(sq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_CLEAR;
      clr_q        <= '0;
      upd_q        <= '0;
      hn_q         <= '0;
      res_re_q     <= '0;
      res_im_q     <= '0;
      res_st_q     <= ST_OK;
      out_valid_o  <= 1'b0;
      entry_real_o <= '0;
      entry_imag_o <= '0;
      status_o     <= '0;
      highest_node_seen_o <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) clr_q <= clr_q + 1'b1;
      if (pop_o) begin
        upd_q    <= '0;
        res_re_q <= '0;
        res_im_q <= '0;
        res_st_q <= item_i.cls;
      end
      if (state_q == B_RDW) begin
        if (it_q.cmd == CMD_READ) begin
          res_re_q <= rdata_q[2*ENTRY_W-1:ENTRY_W];
          res_im_q <= rdata_q[ENTRY_W-1:0];
        end else begin
          upd_q <= upd_q + 1'b1;
          if (sat_re || sat_im) res_st_q <= ST_SAT;
          if (upd_q == 2'd3 && hmax > hn_q) hn_q <= hmax;
        end
      end
      if (state_q == B_DONE && out_free) begin
        out_valid_o         <= 1'b1;
        entry_real_o        <= res_re_q;
        entry_imag_o        <= res_im_q;
        status_o            <= res_st_q;
        highest_node_seen_o <= hn_q;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/admittance_matrix_stamp.sv
`default_nettype none
// Channel | Signals                                         | Direction
// in      | in_valid_i / in_stall_o, command_i .. charging_i | request into the block
// out     | out_valid_o / out_stall_i, entry_*_o, status_o   | one result per request
//
// From the accepting edge to out_valid_o, a stamp goes through pop, two setup states, the
// bit-serial divider (32 + 2*FRAC_BITS steps and a done step) and four read-modify-writes
// on the matrix store, each a read state and a write state. A read goes through pop, B_RD,
// B_RDW and B_DONE; a flagged request through pop and B_DONE. The back end holds its
// result while out stalls. After reset a clearing pass zeroes all MAX_NODES*MAX_NODES store
// entries; in_stall_o stays high meanwhile. A two-entry queue splits classification from
// execution, and the output register lets the queue keep filling while out stalls.
module admittance_matrix_stamp #(
  parameter int MAX_NODES = 64,
  parameter int FRAC_BITS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic [6:0]  from_node_i,
  input  wire logic [6:0]  to_node_i,
  input  wire logic [31:0] resistance_i,
  input  wire logic [31:0] reactance_i,
  input  wire logic [31:0] charging_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [47:0]      entry_real_o,
  output logic [47:0]      entry_imag_o,
  output logic [6:0]       highest_node_seen_o,
  output logic [1:0]       status_o
);
  import amsp_pkg::*;

  item_t fe_item, q_item;
  logic  push, pop, q_full, q_empty, clearing;

  // front: range and zero-impedance checks happen here, before queueing
  amsp_front #(.MAX_NODES(MAX_NODES)) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .from_node_i  (from_node_i),
    .to_node_i    (to_node_i),
    .resistance_i (resistance_i),
    .reactance_i  (reactance_i),
    .charging_i   (charging_i),
    .q_full_i     (q_full),
    .clearing_i   (clearing),
    .push_o       (push),
    .item_o       (fe_item)
  );

  amsp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fe_item),
    .pop_i   (pop),
    .item_o  (q_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: admittance divide, matrix updates, result register
  amsp_back #(.MAX_NODES(MAX_NODES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .item_i              (q_item),
    .empty_i             (q_empty),
    .pop_o               (pop),
    .clearing_o          (clearing),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .entry_real_o        (entry_real_o),
    .entry_imag_o        (entry_imag_o),
    .highest_node_seen_o (highest_node_seen_o),
    .status_o            (status_o)
  );

endmodule
`default_nettype wire
